// File: rtl/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// lpfc_pkg
// Shared types and constants for the length-prefixed frame checker.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    localparam int BYTE_W      = 8;
    localparam int OUT_TDATA_W = 48;

    localparam logic [BYTE_W-1:0] MAX_LEN_RESET  = 8'd200;
    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN  = 8'd4;
    localparam logic [BYTE_W-1:0] HEADER_BYTES   = 8'd3;
    localparam logic [BYTE_W-1:0] POS_CODE       = 8'd0;
    localparam logic [BYTE_W-1:0] POS_LENGTH     = 8'd1;
    localparam logic [BYTE_W-1:0] POS_COMMAND    = 8'd2;

    typedef enum logic [1:0]
    {
        STATUS_OK      = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_LONG    = 2'd2,
        STATUS_BAD_SUM = 2'd3
    } status_t;

    // One result per received byte
    typedef struct packed
    {
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] command_byte;
        logic [BYTE_W-1:0] response_code;
        status_t           frame_status;
        logic              frame_end;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] byte_value;
    } result_t;

endpackage

// File: rtl/lpfc_parser.sv
// ----------------------------------------------------------------------------
// lpfc_parser
// Frame state (position, length, running sum, header bytes) and the result
// for the byte currently presented.
// ----------------------------------------------------------------------------
module lpfc_parser
    import lpfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] max_len,
    output result_t           result
);

    logic [BYTE_W-1:0] pos_reg,  pos_next;
    logic [BYTE_W-1:0] len_reg,  len_next;
    logic [BYTE_W-1:0] sum_reg,  sum_next;
    logic [BYTE_W-1:0] code_reg, code_next;
    logic [BYTE_W-1:0] cmd_reg,  cmd_next;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W:0]   pos_inc;
    logic              at_last;

    assign sum_add = sum_reg + rx_byte;
    assign pos_inc = {1'b0, pos_reg} + {{BYTE_W{1'b0}}, 1'b1};
    assign at_last = (pos_reg >= HEADER_BYTES) && (pos_inc >= {1'b0, len_reg});

    // Decode the byte by its position in the frame
    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        sum_next  = sum_reg;
        code_next = code_reg;
        cmd_next  = cmd_reg;

        result.byte_value    = rx_byte;
        result.byte_index    = pos_reg;
        result.frame_end     = 1'b0;
        result.frame_status  = STATUS_OK;
        result.response_code = code_reg;
        result.command_byte  = cmd_reg;
        result.frame_length  = len_reg;

        priority if (pos_reg == POS_CODE)
        begin
            code_next = rx_byte;
            cmd_next  = '0;
            len_next  = '0;
            sum_next  = rx_byte;
            pos_next  = POS_LENGTH;
            result.response_code = rx_byte;
            result.command_byte  = '0;
            result.frame_length  = '0;
        end
        else if (pos_reg == POS_LENGTH)
        begin
            result.command_byte = '0;
            result.frame_length = rx_byte;
            priority if (rx_byte < MIN_FRAME_LEN)
            begin
                result.frame_end    = 1'b1;
                result.frame_status = STATUS_SHORT;
            end
            else if (rx_byte > max_len)
            begin
                result.frame_end    = 1'b1;
                result.frame_status = STATUS_LONG;
            end
            else
            begin
                len_next = rx_byte;
                sum_next = sum_add;
                pos_next = POS_COMMAND;
            end
        end
        else
        begin
            if (pos_reg == POS_COMMAND)
            begin
                cmd_next            = rx_byte;
                result.command_byte = rx_byte;
            end
            sum_next = sum_add;
            if (at_last)
            begin
                result.frame_end    = 1'b1;
                result.frame_status = (sum_add == '0) ? STATUS_OK : STATUS_BAD_SUM;
            end
            else
            begin
                pos_next = pos_inc[BYTE_W-1:0];
            end
        end

        // Start over after any frame end
        if (result.frame_end)
        begin
            pos_next  = '0;
            len_next  = '0;
            sum_next  = '0;
            code_next = '0;
            cmd_next  = '0;
        end
    end

    // Advance frame state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            sum_reg  <= '0;
            code_reg <= '0;
            cmd_reg  <= '0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            sum_reg  <= sum_next;
            code_reg <= code_next;
            cmd_reg  <= cmd_next;
        end
    end

endmodule

// File: rtl/length_prefixed_frame_checker.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker
// Parses code/length/command/payload/checksum frames from a byte stream.
// ----------------------------------------------------------------------------
// Each received byte yields one output transaction in the cycle after it is
// taken, carrying the byte, its index in the frame and the frame header seen
// so far; tlast marks the byte that closes a frame, with frame_status giving
// ok, too short, too long (against cfg_wr_data as written) or checksum
// mismatch. The block takes one byte per clock: the frame state updates on
// each accepted byte and the output register accepts a new byte whenever it
// is empty or being drained; s_axis_tready drops only while a result stalls.
// Write the maximum frame length only while the stream is idle.
module length_prefixed_frame_checker
    import lpfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] rx_byte
    input  logic [BYTE_W-1:0]      s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] byte_value, [15:8] byte_index, [17:16] frame_status,
    // [25:18] response_code, [33:26] command_byte, [41:34] frame_length,
    // [47:42] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // frame_end
    output logic                   m_axis_tlast,
    input  logic                   cfg_wr_en,
    input  logic [BYTE_W-1:0]      cfg_wr_data
);

    logic [BYTE_W-1:0] max_len_reg;
    logic              in_accept;
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Hold the maximum frame length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    lpfc_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_accept),
        .rx_byte (s_axis_tdata),
        .max_len (max_len_reg),
        .result  (res_next)
    );

    // Track output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    // Load the result register on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = res_reg.frame_end;
    assign m_axis_tdata  = {6'd0,
                            res_reg.frame_length,
                            res_reg.command_byte,
                            res_reg.response_code,
                            res_reg.frame_status,
                            res_reg.byte_index,
                            res_reg.byte_value};

endmodule

// File: rtl/lpfc_checker.sv
// ----------------------------------------------------------------------------
// lpfc_checker
// Port-level checks on the frame checker's output stream.
// ----------------------------------------------------------------------------
module lpfc_checker
    import lpfc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [BYTE_W-1:0]      s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    logic out_xfer;
    logic in_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // Each accepted byte shows up on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> m_axis_tvalid && (m_axis_tdata[7:0] == $past(s_axis_tdata)))
        else $error("accepted byte not presented");

    // Status is ok except on the last byte of a frame
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !m_axis_tlast |-> m_axis_tdata[17:16] == STATUS_OK)
        else $error("status set on a non-final byte");

    // Length rejects end the frame at the length byte
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && (m_axis_tdata[17:16] == STATUS_SHORT ||
                     m_axis_tdata[17:16] == STATUS_LONG)
        |-> m_axis_tlast && m_axis_tdata[15:8] == 8'd1)
        else $error("length reject not at the length byte");

    // The code byte carries no length or command yet
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && m_axis_tdata[15:8] == 8'd0
        |-> !m_axis_tlast && m_axis_tdata[41:26] == 16'd0)
        else $error("bad header fields at the code byte");

endmodule

bind length_prefixed_frame_checker lpfc_checker u_lpfc_checker (.*);
